// File: src/flux_table_interp_adapt_defines.svh
// Assertion macros for the flux table block.
// Used by the top level only; no other dependencies.
`ifndef FLUX_TABLE_INTERP_ADAPT_DEFINES_SVH
`define FLUX_TABLE_INTERP_ADAPT_DEFINES_SVH
`ifndef SYNTHESIS
`define FTIA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ftia assertion failed");
`define FTIA_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("ftia assertion failed");
`else
`define FTIA_ASSERT(lbl, prop)
`define FTIA_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// File: src/ftia_pkg.sv
// Shared types and constants of the flux table block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ftia_pkg;

  localparam int ANGLE_POINTS_DEF   = 64;
  localparam int CURRENT_POINTS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF    = 2;

  // widest grid index and table address over the parameter range
  localparam int IDX_MAX_W  = 10;
  localparam int ADDR_MAX_W = 20;

  localparam logic [23:0] CURRENT_GAIN_RST    = 24'd62;
  localparam logic [14:0] CURRENT_LIMIT_RST   = 15'd32767;
  localparam logic [15:0] CORRECTION_GAIN_RST = 16'd0;
  localparam logic [17:0] RADIUS_SQ_RST       = 18'd65536;

  localparam logic [1:0] REG_CURRENT_GAIN    = 2'd0;
  localparam logic [1:0] REG_CURRENT_LIMIT   = 2'd1;
  localparam logic [1:0] REG_CORRECTION_GAIN = 2'd2;
  localparam logic [1:0] REG_RADIUS_SQ       = 2'd3;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_LOOKUP  = 2'd1;
  localparam logic [1:0] REQ_CORRECT = 2'd2;

  typedef struct packed {
    logic [23:0] current_gain;
    logic [14:0] current_limit;
    logic [15:0] correction_gain;
    logic [17:0] radius_sq_limit;
  } cfg_t;

  // one classified item as it travels from front to back
  typedef struct packed {
    logic [1:0]            req;
    logic                  ld_ok;
    logic [ADDR_MAX_W-1:0] ld_addr;
    logic [IDX_MAX_W-1:0]  x0;
    logic [15:0]           fx;
    logic [IDX_MAX_W-1:0]  y0;
    logic [15:0]           fy;
    logic [31:0]           sqx0;
    logic [31:0]           sqx1;
    logic [31:0]           sqy0;
    logic [31:0]           sqy1;
    logic signed [23:0]    val;   // load word or correction delta
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_LRD,
    B_LMUL,
    B_LACC,
    B_LFIN,
    B_CRD,
    B_CWR
  } bstate_t;

endpackage
`default_nettype wire

// File: src/flux_table_interp_adapt.sv
// Flux linkage table over angle and current with bilinear lookup and
// in-place correction; top level. Uses ftia_pkg, ftia_front, ftia_queue,
// ftia_back, ftia_ram and the assertion macro header.
//
// An item is taken when start is high and busy is low; each item gives one
// result, shown for a single cycle with out_valid, and the receiver cannot
// hold it off. The front end locates the point in its registered stages,
// then hands the item to a two-entry queue; busy stays high while a stage
// holds an item or the queue is full. The back end owns the single table
// RAM port pair, takes the next item only when it is done with the last and
// sets the throughput: a load is one write, a correction a read and a write
// per node (four nodes), a lookup a read, split multiply and accumulate for
// each of four neighbours, then rounding. The table has no reset and must
// be loaded before use.
`timescale 1ns / 1ps
`default_nettype none
`include "flux_table_interp_adapt_defines.svh"
module flux_table_interp_adapt #(
  parameter int ANGLE_POINTS   = ftia_pkg::ANGLE_POINTS_DEF,
  parameter int CURRENT_POINTS = ftia_pkg::CURRENT_POINTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [15:0]        in_angle,
  input  wire logic signed [15:0] in_current,
  input  wire logic [5:0]         in_angle_index,
  input  wire logic [4:0]         in_current_index,
  input  wire logic signed [23:0] in_value,
  output logic                    out_valid,
  output logic signed [23:0]      out_flux,
  output logic [31:0]             out_correction_count,
  output logic [2:0]              out_nodes_updated,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  localparam int DEPTH = ANGLE_POINTS * CURRENT_POINTS;
  localparam int AW    = $clog2(DEPTH);

  ftia_pkg::cfg_t  cfg_r;
  ftia_pkg::item_t push_item, pop_item;
  logic push, pop, q_empty, q_full;
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [23:0] ram_wdata, ram_rdata;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_gain    <= ftia_pkg::CURRENT_GAIN_RST;
      cfg_r.current_limit   <= ftia_pkg::CURRENT_LIMIT_RST;
      cfg_r.correction_gain <= ftia_pkg::CORRECTION_GAIN_RST;
      cfg_r.radius_sq_limit <= ftia_pkg::RADIUS_SQ_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        ftia_pkg::REG_CURRENT_GAIN:    cfg_r.current_gain    <= pwdata[23:0];
        ftia_pkg::REG_CURRENT_LIMIT:   cfg_r.current_limit   <= pwdata[14:0];
        ftia_pkg::REG_CORRECTION_GAIN: cfg_r.correction_gain <= pwdata[15:0];
        ftia_pkg::REG_RADIUS_SQ:       cfg_r.radius_sq_limit <= pwdata[17:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ftia_pkg::REG_CURRENT_GAIN:    prdata = 32'(cfg_r.current_gain);
      ftia_pkg::REG_CURRENT_LIMIT:   prdata = 32'(cfg_r.current_limit);
      ftia_pkg::REG_CORRECTION_GAIN: prdata = 32'(cfg_r.correction_gain);
      ftia_pkg::REG_RADIUS_SQ:       prdata = 32'(cfg_r.radius_sq_limit);
      default:                       prdata = '0;
    endcase
  end

  ftia_front #(
    .ANGLE_POINTS   (ANGLE_POINTS),
    .CURRENT_POINTS (CURRENT_POINTS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_angle         (in_angle),
    .in_current       (in_current),
    .in_angle_index   (in_angle_index),
    .in_current_index (in_current_index),
    .in_value         (in_value),
    .cfg              (cfg_r),
    .queue_full       (q_full),
    .push             (push),
    .push_item        (push_item)
  );

  ftia_queue #(
    .DEPTH (ftia_pkg::QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  ftia_back #(
    .ANGLE_POINTS   (ANGLE_POINTS),
    .CURRENT_POINTS (CURRENT_POINTS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .queue_empty          (q_empty),
    .pop_item             (pop_item),
    .pop                  (pop),
    .ram_we               (ram_we),
    .ram_waddr            (ram_waddr),
    .ram_wdata            (ram_wdata),
    .ram_raddr            (ram_raddr),
    .ram_rdata            (ram_rdata),
    .out_valid            (out_valid),
    .out_flux             (out_flux),
    .out_correction_count (out_correction_count),
    .out_nodes_updated    (out_nodes_updated)
  );

  ftia_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `FTIA_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
  `FTIA_ASSERT(a_nodes_range, out_valid |-> (out_nodes_updated <= 3'd4))
  `FTIA_ASSERT(a_flux_or_nodes, (out_valid && out_flux != 24'sd0) |-> (out_nodes_updated == 3'd0))
endmodule
`default_nettype wire

// File: src/ftia_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ftia_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/ftia_queue.sv
// Small register FIFO between front and back.
// Uses ftia_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none
module ftia_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ftia_pkg::item_t push_item,
  input  wire logic           pop,
  output ftia_pkg::item_t     pop_item,
  output logic                empty,
  output logic                full
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ftia_pkg::item_t slot_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CW'(DEPTH));
  assign pop_item = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

// File: src/ftia_front.sv
// Front end: accepts items, clamps current, locates the point on the grid
// and precomputes squared offsets and the correction delta. Uses ftia_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ftia_front #(
  parameter int ANGLE_POINTS   = ftia_pkg::ANGLE_POINTS_DEF,
  parameter int CURRENT_POINTS = ftia_pkg::CURRENT_POINTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [15:0]        in_angle,
  input  wire logic signed [15:0] in_current,
  input  wire logic [5:0]         in_angle_index,
  input  wire logic [4:0]         in_current_index,
  input  wire logic signed [23:0] in_value,
  input  wire ftia_pkg::cfg_t     cfg,
  input  wire logic               queue_full,
  output logic                    push,
  output ftia_pkg::item_t         push_item
);
  localparam int IW  = ftia_pkg::IDX_MAX_W;
  localparam int AMW = ftia_pkg::ADDR_MAX_W;
  localparam int XQW = 16 + $clog2(ANGLE_POINTS);
  localparam logic [38:0] Y_TOP = 39'(CURRENT_POINTS - 1) << 16;

  // stage 1
  logic               s1_v_r;
  logic [1:0]         s1_req_r;
  logic [IW-1:0]      s1_x0_r;
  logic [15:0]        s1_fx_r;
  logic [14:0]        s1_cur_r;
  logic [5:0]         s1_ai_r;
  logic [4:0]         s1_ci_r;
  logic signed [23:0] s1_val_r;
  // stage 2
  logic               s2_v_r;
  logic [1:0]         s2_req_r;
  logic [IW-1:0]      s2_x0_r;
  logic [15:0]        s2_fx_r;
  logic [38:0]        s2_yprod_r;
  logic signed [40:0] s2_dprod_r;
  logic [31:0]        s2_sqx0_r, s2_sqx1_r;
  logic               s2_ld_ok_r;
  logic [AMW-1:0]     s2_addr_r;
  logic signed [23:0] s2_val_r;

  logic          accept;
  logic [14:0]   hi;
  logic [14:0]   cur_c;
  logic [XQW-1:0] xq;
  logic [15:0]   fx_n;
  logic [38:0]   yq;
  logic [15:0]   fy, fy_n;
  logic signed [40:0] dround;

  assign busy   = s1_v_r | s2_v_r | queue_full;
  assign accept = start & ~busy;

  always_comb begin
    hi = (cfg.current_limit == '0) ? '0 : cfg.current_limit - 15'd1;
    if (in_current[15]) begin
      cur_c = '0;
    end else if (in_current[14:0] > hi) begin
      cur_c = hi;
    end else begin
      cur_c = in_current[14:0];
    end
    xq = XQW'(in_angle) * XQW'(ANGLE_POINTS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
  end

  assign fx_n = 16'd0 - s1_fx_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r <= in_req_type;
      s1_x0_r  <= IW'(xq >> 16);
      s1_fx_r  <= xq[15:0];
      s1_cur_r <= cur_c;
      s1_ai_r  <= in_angle_index;
      s1_ci_r  <= in_current_index;
      s1_val_r <= in_value;
    end
    if (s1_v_r) begin
      s2_req_r   <= s1_req_r;
      s2_x0_r    <= s1_x0_r;
      s2_fx_r    <= s1_fx_r;
      s2_yprod_r <= 39'(s1_cur_r) * 39'(cfg.current_gain);
      s2_dprod_r <= 41'($signed({1'b0, cfg.correction_gain}) * s1_val_r);
      s2_sqx0_r  <= 32'(s1_fx_r) * 32'(s1_fx_r);
      // offset to the ceil node; zero when the point sits on the grid line
      s2_sqx1_r  <= 32'(fx_n) * 32'(fx_n);
      s2_ld_ok_r <= (int'(s1_ai_r) < ANGLE_POINTS) && (int'(s1_ci_r) < CURRENT_POINTS);
      s2_addr_r  <= AMW'(s1_ai_r) * AMW'(CURRENT_POINTS) + AMW'(s1_ci_r);
      s2_val_r   <= s1_val_r;
    end
  end

  always_comb begin
    yq     = (s2_yprod_r > Y_TOP) ? Y_TOP : s2_yprod_r;
    fy     = yq[15:0];
    fy_n   = 16'd0 - fy;
    dround = s2_dprod_r + 41'sd32768;

    push              = s2_v_r;
    push_item.req     = s2_req_r;
    push_item.ld_ok   = s2_ld_ok_r;
    push_item.ld_addr = s2_addr_r;
    push_item.x0      = s2_x0_r;
    push_item.fx      = s2_fx_r;
    push_item.y0      = IW'(yq >> 16);
    push_item.fy      = fy;
    push_item.sqx0    = s2_sqx0_r;
    push_item.sqx1    = s2_sqx1_r;
    push_item.sqy0    = 32'(fy) * 32'(fy);
    push_item.sqy1    = 32'(fy_n) * 32'(fy_n);
    push_item.val     = (s2_req_r == ftia_pkg::REQ_LOAD) ? s2_val_r : dround[39:16];
  end
endmodule
`default_nettype wire

// File: src/ftia_back.sv
// Back end: sequencer that runs loads, lookups and corrections against the
// table RAM and presents one result per item. Uses ftia_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ftia_back #(
  parameter int ANGLE_POINTS   = ftia_pkg::ANGLE_POINTS_DEF,
  parameter int CURRENT_POINTS = ftia_pkg::CURRENT_POINTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ftia_pkg::cfg_t     cfg,
  input  wire logic               queue_empty,
  input  wire ftia_pkg::item_t    pop_item,
  output logic                    pop,
  output logic                    ram_we,
  output logic [$clog2(ANGLE_POINTS*CURRENT_POINTS)-1:0] ram_waddr,
  output logic [23:0]             ram_wdata,
  output logic [$clog2(ANGLE_POINTS*CURRENT_POINTS)-1:0] ram_raddr,
  input  wire logic [23:0]        ram_rdata,
  output logic                    out_valid,
  output logic signed [23:0]      out_flux,
  output logic [31:0]             out_correction_count,
  output logic [2:0]              out_nodes_updated
);
  localparam int AW = $clog2(ANGLE_POINTS * CURRENT_POINTS);
  localparam int IW = ftia_pkg::IDX_MAX_W;

  ftia_pkg::bstate_t state_r, state_nxt;
  ftia_pkg::item_t   it_r;
  logic [1:0]         k_r;
  logic [32:0]        w_r;
  logic signed [40:0] plo_r;
  logic signed [41:0] phi_r;
  logic signed [56:0] acc_r;
  logic               qual_r;
  logic signed [23:0] flux_r;
  logic [2:0]         nodes_r;
  logic [31:0]        cnt_r;
  logic               done_r;

  logic [IW-1:0] x1, y1, xa, ya;
  logic [IW:0]   yc;
  logic [16:0]   gx, gy, wx, wy;
  logic [AW-1:0] lk_addr, cr_addr;
  logic [32:0]   d2;
  logic          node_ok;
  logic signed [56:0] rsum;
  logic signed [24:0] rq, csum;
  logic signed [23:0] csat;

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    if (v > 25'sd8388607) begin
      return 24'sd8388607;
    end else if (v < -25'sd8388608) begin
      return -24'sd8388608;
    end
    return v[23:0];
  endfunction

  // grid neighbours and weights for entry k
  always_comb begin
    x1 = (it_r.x0 == IW'(ANGLE_POINTS - 1)) ? '0 : it_r.x0 + IW'(1);
    y1 = (it_r.y0 == IW'(CURRENT_POINTS - 1)) ? it_r.y0 : it_r.y0 + IW'(1);
    gx = 17'd65536 - 17'(it_r.fx);
    gy = 17'd65536 - 17'(it_r.fy);
    wx = k_r[0] ? 17'(it_r.fx) : gx;
    wy = k_r[1] ? 17'(it_r.fy) : gy;
    lk_addr = AW'(k_r[0] ? x1 : it_r.x0) * AW'(CURRENT_POINTS)
            + AW'(k_r[1] ? y1 : it_r.y0);
    // correction nodes: k[1] picks the angle side, k[0] the current side
    xa = (k_r[1] && it_r.fx != '0) ? x1 : it_r.x0;
    yc = (k_r[0] && it_r.fy != '0) ? (IW + 1)'(it_r.y0) + (IW + 1)'(1)
                                   : (IW + 1)'(it_r.y0);
    ya = yc[IW-1:0];
    cr_addr = AW'(xa) * AW'(CURRENT_POINTS) + AW'(ya);
    d2 = 33'(k_r[1] ? it_r.sqx1 : it_r.sqx0) + 33'(k_r[0] ? it_r.sqy1 : it_r.sqy0);
    node_ok = (34'(d2) < {cfg.radius_sq_limit, 16'd0})
           && (int'(yc) < CURRENT_POINTS);
    rsum = acc_r + 57'sd2147483648;
    rq   = rsum[56:32];
    csum = 25'($signed(ram_rdata)) + 25'(it_r.val);
    csat = sat24(csum);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ftia_pkg::B_IDLE: begin
        if (!queue_empty) begin
          case (pop_item.req)
            ftia_pkg::REQ_LOAD:    state_nxt = ftia_pkg::B_LOAD;
            ftia_pkg::REQ_LOOKUP:  state_nxt = ftia_pkg::B_LRD;
            ftia_pkg::REQ_CORRECT: state_nxt = ftia_pkg::B_CRD;
            default:               state_nxt = ftia_pkg::B_IDLE;
          endcase
        end
      end
      ftia_pkg::B_LOAD: state_nxt = ftia_pkg::B_IDLE;
      ftia_pkg::B_LRD:  state_nxt = ftia_pkg::B_LMUL;
      ftia_pkg::B_LMUL: state_nxt = ftia_pkg::B_LACC;
      ftia_pkg::B_LACC: state_nxt = (k_r == 2'd3) ? ftia_pkg::B_LFIN : ftia_pkg::B_LRD;
      ftia_pkg::B_LFIN: state_nxt = ftia_pkg::B_IDLE;
      ftia_pkg::B_CRD:  state_nxt = ftia_pkg::B_CWR;
      ftia_pkg::B_CWR:  state_nxt = (k_r == 2'd3) ? ftia_pkg::B_IDLE : ftia_pkg::B_CRD;
      default:          state_nxt = ftia_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cr_addr;
    ram_wdata = csat;
    ram_raddr = cr_addr;
    unique case (state_r)
      ftia_pkg::B_IDLE: pop = ~queue_empty;
      ftia_pkg::B_LOAD: begin
        ram_we    = it_r.ld_ok;
        ram_waddr = AW'(it_r.ld_addr);
        ram_wdata = it_r.val;
      end
      ftia_pkg::B_LRD:  ram_raddr = lk_addr;
      ftia_pkg::B_CWR:  ram_we    = qual_r;
      default: begin
      end
    endcase
  end

  assign out_valid            = done_r;
  assign out_flux             = flux_r;
  assign out_correction_count = cnt_r;
  assign out_nodes_updated    = nodes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ftia_pkg::B_IDLE;
      k_r     <= '0;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= 1'b0;
      unique case (state_r)
        ftia_pkg::B_IDLE: begin
          k_r <= '0;
          // an unknown request finishes at once
          if (!queue_empty && pop_item.req != ftia_pkg::REQ_LOAD
              && pop_item.req != ftia_pkg::REQ_LOOKUP
              && pop_item.req != ftia_pkg::REQ_CORRECT) begin
            done_r <= 1'b1;
          end
        end
        ftia_pkg::B_LOAD: begin
          cnt_r  <= '0;
          done_r <= 1'b1;
        end
        ftia_pkg::B_LACC: k_r <= k_r + 2'd1;
        ftia_pkg::B_LFIN: done_r <= 1'b1;
        ftia_pkg::B_CWR: begin
          k_r <= k_r + 2'd1;
          if (qual_r) begin
            cnt_r <= cnt_r + 32'd1;
          end
          if (k_r == 2'd3) begin
            done_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ftia_pkg::B_IDLE: begin
        it_r    <= pop_item;
        acc_r   <= '0;
        flux_r  <= '0;
        nodes_r <= '0;
      end
      ftia_pkg::B_LRD:  w_r <= 33'(wx) * 33'(wy);
      ftia_pkg::B_LMUL: begin
        // weight split in two halves to keep each product narrow
        plo_r <= 41'($signed(ram_rdata) * $signed({1'b0, w_r[15:0]}));
        phi_r <= 42'($signed(ram_rdata) * $signed({1'b0, w_r[32:16]}));
      end
      ftia_pkg::B_LACC: acc_r <= acc_r + 57'(plo_r) + (57'(phi_r) <<< 16);
      ftia_pkg::B_LFIN: flux_r <= sat24(rq);
      ftia_pkg::B_CRD:  qual_r <= node_ok;
      ftia_pkg::B_CWR: begin
        if (qual_r) begin
          nodes_r <= nodes_r + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

// File: tb/flux_table_checker.sv
// Watches the item, result and register channels of flux_table_interp_adapt,
// predicts each result and compares it. Depends on ftia_pkg.
`timescale 1ns / 1ps
module flux_table_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [15:0]        in_angle,
  input  logic signed [15:0] in_current,
  input  logic [5:0]         in_angle_index,
  input  logic [4:0]         in_current_index,
  input  logic signed [23:0] in_value,
  input  logic               out_valid,
  input  logic signed [23:0] out_flux,
  input  logic [31:0]        out_correction_count,
  input  logic [2:0]         out_nodes_updated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 errors,
  output int                 pending
);
  import ftia_pkg::*;

  localparam longint FLUX_HI = 64'sd8388607;
  localparam longint FLUX_LO = -64'sd8388608;

  typedef struct packed {
    logic signed [23:0] flux;
    logic [31:0]        count;
    logic [2:0]         nodes;
  } result_t;

  result_t     expected_q[$];
  logic signed [23:0] flux_mem[0:2047];
  logic [31:0] node_count;
  logic [23:0] gain_r;
  logic [14:0] limit_r;
  logic [15:0] corr_gain_r;
  logic [17:0] radius_r;

  function automatic longint sat_flux(longint v);
    if (v > FLUX_HI) return FLUX_HI;
    if (v < FLUX_LO) return FLUX_LO;
    return v;
  endfunction

  function automatic longint round_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // angle row/fraction and current column/fraction of a point, Q16
  task automatic find_cell(input logic [15:0] ang, input logic signed [15:0] cur,
                           output int x0, output longint fx,
                           output int y0, output longint fy);
    longint c, hi, yq;
    c  = cur;
    hi = (limit_r > 0) ? longint'(limit_r) - 1 : 0;
    if (c < 0) c = 0;
    if (c > hi) c = hi;
    yq = c * longint'(gain_r);
    if (yq > (64'sd31 <<< 16)) yq = 64'sd31 <<< 16;
    x0 = ang[15:10];
    fx = {ang[9:0], 6'b0};
    y0 = int'(yq >>> 16);
    fy = yq & 64'hFFFF;
  endtask

  task automatic predict(output result_t r);
    int x0, y0, x1, y1, xs[2], ys[2];
    longint fx, fy, gx, gy, acc, delta, dxs[2], dys[2], d2;
    r = '0;
    case (in_req_type)
      REQ_LOAD: begin
        flux_mem[{in_angle_index, in_current_index}] = in_value;
        node_count = 0;
      end
      REQ_LOOKUP: begin
        find_cell(in_angle, in_current, x0, fx, y0, fy);
        x1 = (x0 + 1) % 64;
        y1 = (y0 + 1 < 32) ? y0 + 1 : 31;
        gx = 65536 - fx;
        gy = 65536 - fy;
        acc = gx * gy * longint'(flux_mem[x0 * 32 + y0])
            + fx * gy * longint'(flux_mem[x1 * 32 + y0])
            + gx * fy * longint'(flux_mem[x0 * 32 + y1])
            + fx * fy * longint'(flux_mem[x1 * 32 + y1]);
        r.flux = 24'(sat_flux(round_shift(acc, 32)));
      end
      REQ_CORRECT: begin
        find_cell(in_angle, in_current, x0, fx, y0, fy);
        delta = round_shift(longint'(corr_gain_r) * longint'(in_value), 16);
        xs[0] = x0;  dxs[0] = fx;
        xs[1] = (fx != 0) ? x0 + 1 : x0;
        dxs[1] = (fx != 0) ? 65536 - fx : 0;
        ys[0] = y0;  dys[0] = fy;
        ys[1] = (fy != 0) ? y0 + 1 : y0;
        dys[1] = (fy != 0) ? 65536 - fy : 0;
        for (int p = 0; p < 2; p++) begin
          for (int q = 0; q < 2; q++) begin
            d2 = dxs[p] * dxs[p] + dys[q] * dys[q];
            if (d2 < (longint'(radius_r) <<< 16) && ys[q] < 32) begin
              flux_mem[(xs[p] % 64) * 32 + ys[q]] =
                24'(sat_flux(longint'(flux_mem[(xs[p] % 64) * 32 + ys[q]]) + delta));
              node_count++;
              r.nodes++;
            end
          end
        end
      end
      default: ;
    endcase
    r.count = node_count;
  endtask

  always @(posedge clk) begin
    result_t r, e;
    if (!rst_n) begin
      expected_q.delete();
      errors      <= 0;
      pending     <= 0;
      node_count  = 0;
      gain_r      = CURRENT_GAIN_RST;
      limit_r     = CURRENT_LIMIT_RST;
      corr_gain_r = CORRECTION_GAIN_RST;
      radius_r    = RADIUS_SQ_RST;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: flux %0d count %0d", out_flux, out_correction_count);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_flux !== e.flux || out_correction_count !== e.count ||
              out_nodes_updated !== e.nodes) begin
            if (out_flux !== e.flux)
              $error("flux: expected %0d, actual %0d", e.flux, out_flux);
            if (out_correction_count !== e.count)
              $error("correction_count: expected %0d, actual %0d", e.count,
                     out_correction_count);
            if (out_nodes_updated !== e.nodes)
              $error("nodes_updated: expected %0d, actual %0d", e.nodes,
                     out_nodes_updated);
            errors <= errors + 1;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_CURRENT_GAIN:    gain_r      = pwdata[23:0];
          REG_CURRENT_LIMIT:   limit_r     = pwdata[14:0];
          REG_CORRECTION_GAIN: corr_gain_r = pwdata[15:0];
          default:             radius_r    = pwdata[17:0];
        endcase
      end
      if (start && !busy) begin
        predict(r);
        expected_q.push_back(r);
      end
      pending <= expected_q.size();
    end
  end
endmodule

// File: tb/testbench.sv
// Top of the flux table testbench: clock, reset, item and register stimulus,
// verdict. Depends on ftia_pkg, flux_table_interp_adapt and flux_table_checker.
`timescale 1ns / 1ps
module testbench;
  import ftia_pkg::*;

  // request code with no operation behind it
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_req_type = '0;
  logic [15:0]        in_angle = '0;
  logic signed [15:0] in_current = '0;
  logic [5:0]         in_angle_index = '0;
  logic [4:0]         in_current_index = '0;
  logic signed [23:0] in_value = '0;
  logic               out_valid;
  logic signed [23:0] out_flux;
  logic [31:0]        out_correction_count;
  logic [2:0]         out_nodes_updated;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors, pending;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  flux_table_interp_adapt dut (.*);

  flux_table_checker checker_i (.*);

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // wait until all results are back, then out the longest lookup latency
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic issue(input logic [1:0] req, input logic [15:0] ang,
                       input logic signed [15:0] cur, input logic [5:0] ai,
                       input logic [4:0] ci, input logic signed [23:0] val);
    int gap;
    logic took;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req; in_angle <= ang; in_current <= cur;
    in_angle_index <= ai; in_current_index <= ci; in_value <= val;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
  endtask

  function automatic logic signed [23:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    logic [15:0] a;
    a = 16'($urandom);
    if ($urandom_range(0, 4) == 0) a[9:0] = '0;  // on a grid line
    return a;
  endfunction

  function automatic logic signed [15:0] rand_current();
    case ($urandom_range(0, 7))
      0: return 16'sh0000;
      1: return 16'sh8000;
      2: return 16'sh7FFF;
      3: return 16'($urandom_range(0, 600));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_items(input int count);
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 19);
      if (k < 3)
        issue(REQ_LOAD, 16'($urandom), 16'($urandom), 6'($urandom), 5'($urandom),
              rand_word());
      else if (k < 11)
        issue(REQ_LOOKUP, rand_angle(), rand_current(), 6'($urandom), 5'($urandom),
              24'($urandom));
      else if (k < 19)
        issue(REQ_CORRECT, rand_angle(), rand_current(), 6'($urandom), 5'($urandom),
              rand_word());
      else
        issue(REQ_UNUSED, 16'($urandom), 16'($urandom), 6'($urandom), 5'($urandom),
              24'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // every entry gets written before anything reads the table
    for (int a = 0; a < 64; a++)
      for (int c = 0; c < 32; c++)
        issue(REQ_LOAD, 16'($urandom), 16'($urandom), 6'(a), 5'(c), rand_word());

    // directed: axis extremes, grid lines, unknown request, saturation
    issue(REQ_LOOKUP, 16'h0000, 16'sh0000, '0, '0, '0);
    issue(REQ_LOOKUP, 16'hFFFF, 16'sh7FFF, '1, '1, '1);
    issue(REQ_LOOKUP, 16'hFC00, 16'sh8000, '0, '0, '0);
    issue(REQ_LOOKUP, 16'h8123, 16'sh0100, '0, '0, '0);
    issue(REQ_UNUSED, 16'hFFFF, 16'shFFFF, '1, '1, '1);
    issue(REQ_CORRECT, 16'h0400, 16'sh0000, '0, '0, 24'sh7FFFFF);
    drain();
    reg_write(REG_CORRECTION_GAIN, 32'h0000FFFF);
    reg_write(REG_RADIUS_SQ, 32'd131072);
    issue(REQ_CORRECT, 16'h0000, 16'sh0000, '0, '0, 24'sh7FFFFF);
    issue(REQ_CORRECT, 16'h0000, 16'sh0000, '0, '0, 24'sh7FFFFF);
    issue(REQ_CORRECT, 16'h0000, 16'sh0000, '0, '0, 24'sh800000);
    issue(REQ_CORRECT, 16'hFFFF, 16'sh7FFF, '0, '0, 24'sh800000);
    issue(REQ_CORRECT, 16'h0200, 16'sh0201, '0, '0, 24'sh123456);
    issue(REQ_LOOKUP, 16'h0000, 16'sh0000, '0, '0, '0);
    issue(REQ_LOOKUP, 16'hFFFF, 16'sh7FFF, '0, '0, '0);
    issue(REQ_LOAD, 16'h0000, 16'sh0000, 6'd63, 5'd31, 24'sh7FFFFF);
    issue(REQ_LOOKUP, 16'hFFFF, 16'sh7FFF, '0, '0, '0);

    random_items(225);
    drain();
    reg_write(REG_CURRENT_GAIN, 32'd16777215);
    reg_write(REG_CURRENT_LIMIT, 32'd1);
    reg_write(REG_RADIUS_SQ, 32'd0);
    random_items(200);
    drain();
    reg_write(REG_CURRENT_GAIN, 32'd1);
    reg_write(REG_CURRENT_LIMIT, 32'd32767);
    reg_write(REG_CORRECTION_GAIN, 32'd0);
    reg_write(REG_RADIUS_SQ, 32'd65536);
    random_items(200);
    drain();
    reg_write(REG_CURRENT_GAIN, 32'd16777215);
    reg_write(REG_CURRENT_LIMIT, 32'd0);
    reg_write(REG_CORRECTION_GAIN, 32'd65535);
    reg_write(REG_RADIUS_SQ, 32'd131072);
    random_items(150);
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      reg_write(REG_CURRENT_GAIN, $urandom_range(100, 4000));
      reg_write(REG_CURRENT_LIMIT, $urandom_range(1, 32767));
      reg_write(REG_CORRECTION_GAIN, $urandom_range(0, 65535));
      reg_write(REG_RADIUS_SQ, $urandom_range(0, 131072));
      random_items(145);
    end

    drain();
    if (errors == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

// File: files.f
+incdir+src
src/ftia_pkg.sv
src/ftia_ram.sv
src/ftia_queue.sv
src/ftia_front.sv
src/ftia_back.sv
src/flux_table_interp_adapt.sv
tb/flux_table_checker.sv
tb/testbench.sv
